FILE: src/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int ID_W  = 16;
   localparam int PRI_W = 16;

   typedef enum logic [1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_POP_EMPTY  = 2'd1,
      STATUS_PUSH_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   // one slot of the queue
   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] priority_v;
   } entry_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] priority_v;
   } op_type;

endpackage

FILE: src/spq_cell.sv
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  op_type    op,
   input  entry_type left_entry,
   input  logic      left_stay,
   input  entry_type right_entry,
   output entry_type entry,
   output logic      stay
);

   logic             valid_ff, valid_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [PRI_W-1:0] pri_ff, pri_in;

   // entry holds its place when it ranks at or above the new one
   assign stay = valid_ff && (pri_ff >= op.priority_v);

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      pri_in   = pri_ff;
      if (op.push) begin
         if (stay) begin
            valid_in = valid_ff;
         end else if (left_stay) begin
            valid_in = 1'b1;
            id_in    = op.id;
            pri_in   = op.priority_v;
         end else begin
            valid_in = left_entry.valid;
            id_in    = left_entry.id;
            pri_in   = left_entry.priority_v;
         end
      end else if (op.pop) begin
         valid_in = right_entry.valid;
         id_in    = right_entry.id;
         pri_in   = right_entry.priority_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      pri_ff <= pri_in;
   end

   assign entry = '{valid: valid_ff, id: id_ff, priority_v: pri_ff};

endmodule

FILE: src/sorted_priority_queue.sv
// Sorted priority queue, DEPTH entries of (id, priority), highest priority first.
// Equal priorities leave in arrival order.
// Request channel: req_valid / req_stall with req_cmd (push or pop), req_item_id
// and req_item_priority. Response channel: rsp_valid / rsp_stall with rsp_status,
// rsp_out_id, rsp_out_priority, rsp_is_empty and rsp_is_full.
// Every request transaction yields exactly one response transaction.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one transaction per cycle unless the receiver stalls. The slots
// form a chain of cells that all compare against the new priority in parallel
// and shift by one slot together, so a push or a pop updates every cell at once.
// A push into a full queue is refused (status push_full); a pop of an empty queue
// reports pop_empty; neither changes the contents.
// Reset (synchronous, active high) empties the queue and drops any pending response.
// When the receiver stalls, the response register holds its transaction and
// req_stall is raised, so no new request is taken until the response drains.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [ID_W-1:0]  req_item_id,
   input  logic [PRI_W-1:0] req_item_priority,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [ID_W-1:0]  rsp_out_id,
   output logic [PRI_W-1:0] rsp_out_priority,
   output logic             rsp_is_empty,
   output logic             rsp_is_full
);

   entry_type entries [DEPTH];
   logic      stays   [DEPTH];
   op_type    op;
   logic      accept;
   logic      is_push, is_pop;
   logic      q_empty, q_full;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [ID_W-1:0]  out_id_ff, out_id_in;
   logic [PRI_W-1:0] out_pri_ff, out_pri_in;
   logic             empty_ff, empty_in;
   logic             full_ff, full_in;

   // the response slot frees up when it is empty or being taken this cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign q_empty = !entries[0].valid;
   assign q_full  = entries[DEPTH-1].valid;
   assign is_push = accept && (cmd_type'(req_cmd) == CMD_PUSH);
   assign is_pop  = accept && (cmd_type'(req_cmd) == CMD_POP);

   // refused operations never reach the cells
   assign op = '{push:       is_push && !q_full,
                 pop:        is_pop && !q_empty,
                 id:         req_item_id,
                 priority_v: req_item_priority};

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         entry_type left_e, right_e;
         logic      left_s;
         if (g == 0) begin : g_head
            assign left_e = '0;
            assign left_s = 1'b1;   // head cell takes the new entry when it yields
         end else begin : g_mid
            assign left_e = entries[g-1];
            assign left_s = stays[g-1];
         end
         if (g == DEPTH-1) begin : g_tail
            assign right_e = '0;    // an empty slot moves in at the tail on pop
         end else begin : g_body
            assign right_e = entries[g+1];
         end
         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (op),
            .left_entry  (left_e),
            .left_stay   (left_s),
            .right_entry (right_e),
            .entry       (entries[g]),
            .stay        (stays[g])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      out_id_in    = out_id_ff;
      out_pri_in   = out_pri_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_id_in    = '0;
         out_pri_in   = '0;
         if (is_push) begin
            empty_in = 1'b0;
            if (q_full) begin
               status_in = STATUS_PUSH_FULL;
               full_in   = 1'b1;
            end else begin
               status_in = STATUS_DONE;
               // full after insert when only the tail slot was free
               full_in   = entries[DEPTH-2].valid;
            end
         end else begin
            full_in = 1'b0;
            if (q_empty) begin
               status_in = STATUS_POP_EMPTY;
               empty_in  = 1'b1;
            end else begin
               status_in  = STATUS_DONE;
               out_id_in  = entries[0].id;
               out_pri_in = entries[0].priority_v;
               empty_in   = !entries[1].valid;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      out_id_ff  <= out_id_in;
      out_pri_ff <= out_pri_in;
      empty_ff   <= empty_in;
      full_ff    <= full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_priority = out_pri_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;

endmodule

FILE: verif/sorted_priority_queue_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_test
   import spq_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction on either side
   localparam int HOLD_CYCLES    = 60;     // long receiver hold-off, fills the pipe
   localparam int DRAIN_CYCLES   = 4;      // settle time after the last response

   // expected response of one request transaction
   typedef struct {
      status_type       status;
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
      logic             empty;
      logic             full;
   } queue_response_type;

   // Shadow copy of the queue contents plus the responses still owed by the DUT.
   class sorted_queue_model;
      logic [ID_W-1:0]    held_id[DEPTH];
      logic [PRI_W-1:0]   held_pri[DEPTH];
      int                 held_count;
      queue_response_type due_responses[$];
      int                 failures;

      function new();
         held_count = 0;
         failures   = 0;
      endfunction

      // apply one accepted request and queue up the response it must produce
      function void take_request(logic cmd, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
         queue_response_type r;
         int                 pos;
         int                 i;
         bit                 found;
         r.status = STATUS_DONE;
         r.id     = '0;
         r.pri    = '0;
         if (cmd == CMD_PUSH) begin
            if (held_count >= DEPTH) begin
               r.status = STATUS_PUSH_FULL;
            end else begin
               // insert behind every entry of equal or higher priority
               pos   = held_count;
               found = 0;
               for (i = 0; i < held_count; i++) begin
                  if (!found && held_pri[i] < pri) begin
                     pos   = i;
                     found = 1;
                  end
               end
               for (i = held_count; i > pos; i--) begin
                  held_id[i]  = held_id[i-1];
                  held_pri[i] = held_pri[i-1];
               end
               held_id[pos]  = id;
               held_pri[pos] = pri;
               held_count++;
            end
         end else begin
            if (held_count == 0) begin
               r.status = STATUS_POP_EMPTY;
            end else begin
               r.id  = held_id[0];
               r.pri = held_pri[0];
               for (i = 0; i + 1 < held_count; i++) begin
                  held_id[i]  = held_id[i+1];
                  held_pri[i] = held_pri[i+1];
               end
               held_count--;
            end
         end
         r.empty = (held_count == 0);
         r.full  = (held_count == DEPTH);
         due_responses.push_back(r);
      endfunction

      // compare one accepted response against the oldest one owed
      function void match_response(logic [1:0] status, logic [ID_W-1:0] id,
                                   logic [PRI_W-1:0] pri, logic empty, logic full);
         queue_response_type e;
         if (due_responses.size() == 0) begin
            $error("response with none outstanding: status %0d id %h priority %h",
                   status, id, pri);
            failures++;
            return;
         end
         e = due_responses.pop_front();
         if (status !== e.status) begin
            $error("rsp_status: expected %0d, got %0d", e.status, status);
            failures++;
         end
         if (id !== e.id) begin
            $error("rsp_out_id: expected %h, got %h", e.id, id);
            failures++;
         end
         if (pri !== e.pri) begin
            $error("rsp_out_priority: expected %h, got %h", e.pri, pri);
            failures++;
         end
         if (empty !== e.empty) begin
            $error("rsp_is_empty: expected %0d, got %0d", e.empty, empty);
            failures++;
         end
         if (full !== e.full) begin
            $error("rsp_is_full: expected %0d, got %0d", e.full, full);
            failures++;
         end
      endfunction

      function int outstanding();
         return due_responses.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_cmd;
   logic [ID_W-1:0]  req_item_id;
   logic [PRI_W-1:0] req_item_priority;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [1:0]       rsp_status;
   logic [ID_W-1:0]  rsp_out_id;
   logic [PRI_W-1:0] rsp_out_priority;
   logic             rsp_is_empty;
   logic             rsp_is_full;

   sorted_queue_model shadow = new();

   // knobs shared between the sender, the receiver and the phase sequencer
   int send_idle_pct = 0;     // chance of an idle burst before a request
   int recv_idle_pct = 0;     // chance of a stall burst on the response side
   bit quiet         = 0;     // final stretch: no idling on either side
   bit hold_request  = 0;     // ask the receiver for one long hold-off

   int quiet_cycles = 0;

   sorted_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_item_id       (req_item_id),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Monitor: sees pre-edge values, so request and response transactions are
   // taken exactly at the edge where the handshake completes. Also runs the
   // watchdog on cycles with no transaction at all.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            shadow.take_request(req_cmd, req_item_id, req_item_priority);
         end
         if (rsp_valid && !rsp_stall) begin
            shadow.match_response(rsp_status, rsp_out_id, rsp_out_priority,
                                  rsp_is_empty, rsp_is_full);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   // Each loop pass covers its own clock edges, so rsp_stall gets one update per step.
   initial begin
      int burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
            burst = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request transaction and hold it until accepted. req_valid stays
   // high into the next call, which either reloads the payload or drops valid.
   task automatic send_request(logic cmd, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
      int gap;
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_item_id       <= id;
      req_item_priority <= pri;
      do @(posedge clock); while (req_stall);
   endtask

   // Random requests with a given push percentage. Priorities lean on a tiny range so ties
   // (arrival-order case) are common, with extremes and full-range values mixed in.
   task automatic run_phase(int items, int push_pct);
      logic             cmd;
      logic [PRI_W-1:0] pri;
      int               n;
      for (n = 0; n < items; n++) begin
         cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
         case ($urandom_range(0, 9))
            0:       pri = '0;
            1:       pri = '1;
            2, 3:    pri = PRI_W'($urandom);
            default: pri = PRI_W'($urandom_range(0, 7));
         endcase
         send_request(cmd, ID_W'($urandom), pri);
      end
   endtask

   initial begin
      int i;
      int phase;
      int push_pct;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_cmd           <= CMD_PUSH;
      req_item_id       <= '0;
      req_item_priority <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pop while empty, fill to capacity with extremes and ties,
      // one refused push on a full queue, then drain part of it.
      send_idle_pct = 25;
      recv_idle_pct = 25;
      send_request(CMD_POP, 16'hFFFF, 16'hFFFF);
      send_request(CMD_PUSH, 16'hFFFF, 16'hFFFF);
      send_request(CMD_PUSH, 16'h0000, 16'h0000);
      send_request(CMD_PUSH, 16'h1234, 16'h0005);
      send_request(CMD_PUSH, 16'h0001, 16'h0005);
      send_request(CMD_PUSH, 16'h0002, 16'h0005);
      send_request(CMD_PUSH, 16'hAAAA, 16'hFFFF);
      send_request(CMD_PUSH, 16'h5555, 16'h0000);
      for (i = 0; i < 9; i++) begin
         send_request(CMD_PUSH, ID_W'(16'h0100 + i), PRI_W'(i % 3));
      end
      send_request(CMD_PUSH, 16'hBEEF, 16'h0008);    // full, must be refused
      for (i = 0; i < 6; i++) begin
         send_request(CMD_POP, 16'h0000, 16'h0000);
      end

      // Random: alternate push-heavy, pop-heavy and balanced phases so the
      // queue keeps swinging between full and empty.
      for (phase = 0; phase < 12; phase++) begin
         case (phase % 3)
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 55;
         endcase
         send_idle_pct = (phase % 4 == 3) ? 0 : 10 * $urandom_range(0, 5);
         recv_idle_pct = (phase % 5 == 4) ? 0 : 10 * $urandom_range(0, 5);
         if (phase == 6) begin
            // back-pressure: receiver holds off while requests keep coming
            send_idle_pct = 0;
            hold_request  = 1;
            push_pct      = 90;
         end
         run_phase(30, push_pct);
      end

      // last stretch at full rate on both sides
      quiet = 1;
      run_phase(60, 55);
      req_valid <= 1'b0;

      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sorted_priority_queue.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
verif/sorted_priority_queue_test.sv
